// ----- design/ventilator_record_deframer_macros.svh -----
// ----------------------------------------------------------------------------
// ventilator_record_deframer_macros.svh
// Assertion macros used by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef VENTILATOR_RECORD_DEFRAMER_MACROS_SVH
`define VENTILATOR_RECORD_DEFRAMER_MACROS_SVH

// Checked only while out of reset.
`define VRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define VRD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/vrd_pkg.sv -----
// ----------------------------------------------------------------------------
// vrd_pkg
// Types and constants of the ventilator record deframer.
// ----------------------------------------------------------------------------
package vrd_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_END_FLAG   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_VALUE_FLAG = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PHASE_FLAG = 2'd2;

  localparam logic [7:0] END_FLAG_RST   = 8'd127;
  localparam logic [7:0] VALUE_FLAG_RST = 8'd190;
  localparam logic [7:0] PHASE_FLAG_RST = 8'd192;

  localparam logic [7:0] HDR_SETTINGS = 8'h53;  // 'S'
  localparam logic [7:0] HDR_BREATH   = 8'h42;  // 'B'
  localparam logic [7:0] HDR_TREND    = 8'h54;  // 'T'
  localparam logic [7:0] HDR_ALARM    = 8'h41;  // 'A'
  localparam logic [7:0] HDR_ERROR    = 8'hE0;

  typedef struct packed {
    logic [7:0] end_flag;
    logic [7:0] value_flag;
    logic [7:0] phase_flag;
  } vrd_cfg_t;

  typedef struct packed {
    logic        record_kind;
    logic [4:0]  value_index;
    logic [15:0] raw_value;
    logic        index_overflow;
  } vrd_result_t;

endpackage

// ----- design/ventilator_record_deframer.sv -----
// ----------------------------------------------------------------------------
// ventilator_record_deframer
// Splits a received byte stream into breath and settings records and emits
// each 16-bit value with its record kind and index.
// ----------------------------------------------------------------------------
// A value is registered in the output register, or the skid stage on a stall.
// Throughput: one byte per cycle; the output register plus a one-entry skid
// stage absorb a stall, and in_stall rises only once the skid stage is full.
// Reset: parser state returns to awaiting header, output is empty and the
// flag registers return to 127, 190 and 192.
// ----------------------------------------------------------------------------
module ventilator_record_deframer #(
  parameter int unsigned MAX_VALUES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_record_kind,
  output logic [4:0]                    out_value_index,
  output logic [15:0]                   out_raw_value,
  output logic                          out_index_overflow,
  input  logic                          cfg_we,
  input  logic [vrd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [vrd_pkg::CfgDataW-1:0]  cfg_wdata
);

  vrd_pkg::vrd_cfg_t    cfg_r;
  vrd_pkg::vrd_result_t res;
  vrd_pkg::vrd_result_t out_r, skid_r;
  logic                 res_valid;
  logic                 out_valid_r, skid_valid_r;
  logic                 in_accept, out_free, new_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.end_flag   <= vrd_pkg::END_FLAG_RST;
      cfg_r.value_flag <= vrd_pkg::VALUE_FLAG_RST;
      cfg_r.phase_flag <= vrd_pkg::PHASE_FLAG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vrd_pkg::CFG_END_FLAG:   cfg_r.end_flag   <= cfg_wdata;
        vrd_pkg::CFG_VALUE_FLAG: cfg_r.value_flag <= cfg_wdata;
        vrd_pkg::CFG_PHASE_FLAG: cfg_r.phase_flag <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign new_res   = in_accept && res_valid;

  vrd_parser #(
    .MAX_VALUES(MAX_VALUES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .rx_byte  (in_rx_byte),
    .cfg      (cfg_r),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || new_res;
      skid_valid_r <= 1'b0;
    end else if (new_res) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (new_res) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_record_kind    = out_r.record_kind;
  assign out_value_index    = out_r.value_index;
  assign out_raw_value      = out_r.raw_value;
  assign out_index_overflow = out_r.index_overflow;

endmodule

// ----- design/vrd_parser.sv -----
// ----------------------------------------------------------------------------
// vrd_parser
// Header decode, byte pairing and record position tracking, one byte per
// accepted transaction.
// ----------------------------------------------------------------------------
module vrd_parser #(
  parameter int unsigned MAX_VALUES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  vrd_pkg::vrd_cfg_t   cfg,
  output logic                res_valid,
  output vrd_pkg::vrd_result_t res
);

  localparam int unsigned PosW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam logic [PosW-1:0] MaxIdx = PosW'(MAX_VALUES - 1);

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_BREATH   = 3'd1;
  localparam logic [2:0] MODE_SETTINGS = 3'd2;
  localparam logic [2:0] MODE_DISCARD  = 3'd3;
  localparam logic [2:0] MODE_ENDFOUND = 3'd4;

  logic [2:0]      mode_r, mode_nxt;
  logic [1:0]      left_r, left_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [7:0]      high_r, high_nxt;
  logic            ovf_r, ovf_nxt;
  logic [PosW+4:0] pos_ext;
  logic            hdr_discard;

  assign pos_ext = {5'b0, pos_r};
  assign hdr_discard = (rx_byte == vrd_pkg::HDR_TREND) || (rx_byte == vrd_pkg::HDR_ALARM) ||
                       (rx_byte == vrd_pkg::HDR_ERROR) || (rx_byte == cfg.value_flag) ||
                       (rx_byte == cfg.phase_flag);

  always_comb begin
    mode_nxt  = mode_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    high_nxt  = high_r;
    ovf_nxt   = ovf_r;
    res_valid = 1'b0;
    case (mode_r)
      MODE_BREATH, MODE_SETTINGS: begin
        if (left_r == 2'd2) begin
          high_nxt = rx_byte;
          left_nxt = 2'd1;
        end else if (left_r == 2'd1) begin
          res_valid = 1'b1;
          left_nxt  = 2'd0;
        end else if (rx_byte == cfg.end_flag) begin
          mode_nxt = MODE_ENDFOUND;
        end else begin
          if (pos_r == MaxIdx) begin
            ovf_nxt = 1'b1;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
          high_nxt = rx_byte;
          left_nxt = 2'd1;
        end
      end
      MODE_DISCARD: begin
        if (rx_byte == cfg.end_flag) begin
          mode_nxt = MODE_ENDFOUND;
        end
      end
      MODE_ENDFOUND: begin
        mode_nxt = MODE_IDLE;
      end
      default: begin
        if (rx_byte == vrd_pkg::HDR_SETTINGS || rx_byte == vrd_pkg::HDR_BREATH) begin
          mode_nxt = (rx_byte == vrd_pkg::HDR_SETTINGS) ? MODE_SETTINGS : MODE_BREATH;
          pos_nxt  = '0;
          left_nxt = 2'd2;
          ovf_nxt  = 1'b0;
        end else if (hdr_discard) begin
          mode_nxt = MODE_DISCARD;
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
    endcase
  end

  assign res.record_kind    = (mode_r == MODE_SETTINGS);
  assign res.value_index    = pos_ext[4:0];
  assign res.raw_value      = {high_r, rx_byte};
  assign res.index_overflow = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      left_r <= 2'd0;
      pos_r  <= '0;
      high_r <= 8'd0;
      ovf_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      left_r <= left_nxt;
      pos_r  <= pos_nxt;
      high_r <= high_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

// ----- design/vrd_checker.sv -----
// ----------------------------------------------------------------------------
// vrd_checker
// Port-level checks of the deframer's result channel and back-pressure.
// ----------------------------------------------------------------------------
`include "ventilator_record_deframer_macros.svh"

module vrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_record_kind,
  input logic [4:0]  out_value_index,
  input logic [15:0] out_raw_value,
  input logic        out_index_overflow
);

  logic [22:0] out_bus;
  logic        out_held;

  assign out_bus  = {out_record_kind, out_value_index, out_raw_value, out_index_overflow};
  assign out_held = out_valid && out_stall;

  `VRD_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "out_valid set after reset")

  `VRD_ASSERT(a_stall_needs_out, in_stall |-> out_valid, "in_stall without a held result")

  `VRD_ASSERT(a_stall_cause, in_stall |-> $past(out_held), "in_stall without a stalled result")

  `VRD_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_bus), "held transaction changed")

endmodule

bind ventilator_record_deframer vrd_checker u_vrd_checker (.*);
